// File: rtl/core/icrp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the convolution block.
package icrp_pkg;

    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_KERNEL     = 7;
    localparam int DEF_COEF_FRAC_BITS = 8;
    localparam int HEIGHT_LIMIT       = 1024;
    localparam int PIX_MAX            = 255;
    localparam int MAX_RESULTS        = 4;

    localparam logic [1:0] FUNC_COEF  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_DRAIN = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef struct packed {
        logic take;
        logic tap_start;
        logic tap_step;
        logic out_load;
        logic col_next;
    } icrp_cmd_t;

    typedef struct packed {
        logic emits;
        logic tap_last;
        logic col_last;
        logic pipe_busy;
        logic out_free;
    } icrp_stat_t;

endpackage

// File: rtl/core/icrp_ram.sv
// Generic simple dual-port RAM with registered read.
module icrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/icrp_ctrl.sv
// Sequencing state machine: item intake, tap sweep per result, result hand-off.
module icrp_ctrl
    import icrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  icrp_stat_t stat,
    output icrp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_TAP  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.emits)
                begin
                    cmd.tap_start = 1'b1;
                    state_next    = S_TAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TAP:
            begin
                cmd.tap_step = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // let the read/multiply/accumulate pipe empty
                if (!stat.pipe_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.col_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.col_next  = 1'b1;
                        cmd.tap_start = 1'b1;
                        state_next    = S_TAP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_take_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == S_PREP))
        else $error("take not followed by decode");

    a_tap_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP && stat.tap_last) |=> (state_reg == S_WAIT))
        else $error("tap sweep did not end after last tap");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && stat.col_last) |=> item_ready)
        else $error("not ready after last result of item");

endmodule

// File: rtl/core/icrp_dp.sv
// Datapath: config, stream position, line store, coefficient table, MAC and result register.
module icrp_dp
    import icrp_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  icrp_cmd_t          cmd,
    output icrp_stat_t         stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic [1:0]         func,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    input  logic [7:0]         pixel,
    input  logic               frame_start,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [7:0]         result_pixel,
    output logic [9:0]         result_column,
    output logic [9:0]         result_row,
    output logic               last_of_run
);

    localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;
    localparam int COEF_COUNT = MAX_KERNEL * MAX_KERNEL;
    localparam int COEF_AW    = $clog2(COEF_COUNT);
    localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int SLOT_W     = $clog2(MAX_KERNEL);
    localparam int TAP_W      = $clog2(MAX_KERNEL);
    localparam int PROD_W     = 25;
    localparam int ACC_W      = PROD_W + $clog2(COEF_COUNT) + 1;

    // configuration
    logic [10:0] width_reg, height_reg;
    logic [1:0]  radius_reg;
    logic [10:0] eff_w, eff_h;
    logic [1:0]  eff_r;
    logic [TAP_W-1:0] side_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            radius_reg <= 2'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 11'd0)
            eff_w = 11'd1;
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = 11'(MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == 11'd0)
            eff_h = 11'd1;
        else if (int'(height_reg) > HEIGHT_LIMIT)
            eff_h = 11'(HEIGHT_LIMIT);
        else
            eff_h = height_reg;
        if (radius_reg == 2'd0)
            eff_r = 2'd1;
        else if (int'(radius_reg) > MAX_RADIUS)
            eff_r = 2'(MAX_RADIUS);
        else
            eff_r = radius_reg;
    end

    assign side_m1 = TAP_W'({eff_r, 1'b0});

    // stream position
    logic [10:0]       row_reg, col_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [10:0]       pos_row, pos_col;
    logic [SLOT_W-1:0] pos_slot;
    logic              is_px, live, row_end, emit, line_we;
    logic [10:0]       lo_col, hi_raw, hi_col;
    logic [11:0]       lo_p3;
    logic [LINE_AW-1:0] line_waddr;

    assign pos_row  = frame_start ? 11'd0 : row_reg;
    assign pos_col  = frame_start ? 11'd0 : col_reg;
    assign pos_slot = frame_start ? '0 : slot_reg;
    assign is_px    = (func == FUNC_PIXEL) || (func == FUNC_DRAIN);
    assign live     = {1'b0, pos_row} < ({1'b0, eff_h} + 12'(eff_r));
    assign row_end  = pos_col >= (eff_w - 11'd1);
    // a column past the row end by more than r (width cut mid-plane) leaves nothing to emit
    assign emit     = is_px && live && (pos_row >= 11'(eff_r))
                      && (row_end || pos_col >= 11'(eff_r)) && (lo_col <= hi_raw);
    assign lo_col   = (pos_col >= 11'(eff_r)) ? pos_col - 11'(eff_r) : 11'd0;
    assign hi_raw   = row_end ? eff_w - 11'd1 : pos_col - 11'(eff_r);
    assign lo_p3    = {1'b0, lo_col} + 12'(MAX_RESULTS - 1);
    assign hi_col   = ({1'b0, hi_raw} > lo_p3) ? lo_p3[10:0] : hi_raw;
    assign line_we  = cmd.take && is_px && live && (pos_row < eff_h)
                      && (int'(pos_col) < MAX_WIDTH);
    assign line_waddr = LINE_AW'(32'(pos_slot) * 32'(MAX_WIDTH)) + LINE_AW'(pos_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cmd.take && is_px && live)
        begin
            if (row_end)
            begin
                col_reg  <= '0;
                row_reg  <= pos_row + 11'd1;
                slot_reg <= (int'(pos_slot) == MAX_KERNEL - 1) ? '0 : pos_slot + 1'b1;
            end
            else
            begin
                col_reg  <= pos_col + 11'd1;
                row_reg  <= pos_row;
                slot_reg <= pos_slot;
            end
        end
    end

    // per-item context
    logic              emits_reg;
    logic [10:0]       item_row_reg, orow_reg, cur_col_reg, hi_col_reg;
    logic [SLOT_W-1:0] item_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emits_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            emits_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_row_reg  <= pos_row;
            item_slot_reg <= pos_slot;
            orow_reg      <= pos_row - 11'(eff_r);
            cur_col_reg   <= lo_col;
            hi_col_reg    <= hi_col;
        end
        else if (cmd.col_next)
        begin
            cur_col_reg <= cur_col_reg + 11'd1;
        end
    end

    // tap sweep
    logic [TAP_W-1:0]   i_reg, j_reg;
    logic [COEF_AW-1:0] k_reg;
    logic               tap_last;

    assign tap_last = (i_reg == side_m1) && (j_reg == side_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.tap_start)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.tap_step)
        begin
            k_reg <= k_reg + 1'b1;
            if (j_reg == side_m1)
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    // tap address: clamped row, its line slot, clamped column
    logic signed [12:0] rr_s, cc_s;
    logic [10:0]        rr, cc, diff;
    logic [SLOT_W-1:0]  rd_slot;
    logic [LINE_AW-1:0] line_raddr;

    assign rr_s = $signed(13'(orow_reg) + 13'(i_reg) - 13'(eff_r));
    assign cc_s = $signed(13'(cur_col_reg) + 13'(j_reg) - 13'(eff_r));

    always_comb
    begin
        if (rr_s < 13'sd0)
            rr = 11'd0;
        else if (rr_s > $signed(13'(eff_h) - 13'sd1))
            rr = eff_h - 11'd1;
        else
            rr = rr_s[10:0];
        if (cc_s < 13'sd0)
            cc = 11'd0;
        else if (cc_s > $signed(13'(eff_w) - 13'sd1))
            cc = eff_w - 11'd1;
        else
            cc = cc_s[10:0];
        diff = item_row_reg - rr;
        if (11'(item_slot_reg) >= diff)
            rd_slot = SLOT_W'(11'(item_slot_reg) - diff);
        else
            rd_slot = SLOT_W'(11'(item_slot_reg) + 11'(MAX_KERNEL) - diff);
    end

    assign line_raddr = LINE_AW'(32'(rd_slot) * 32'(MAX_WIDTH)) + LINE_AW'(cc);

    // storage
    logic [7:0]  line_rd;
    logic [15:0] coef_rd;
    logic        coef_we;

    assign coef_we = cmd.take && (func == FUNC_COEF) && (int'(coef_index) < COEF_COUNT);

    icrp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
        .clk     (clk),
        .we      (line_we),
        .waddr   (line_waddr),
        .wdata   (pixel),
        .re      (cmd.tap_step),
        .raddr   (line_raddr),
        .rd_data (line_rd)
    );

    icrp_ram #(.WIDTH(16), .DEPTH(COEF_COUNT)) u_coef (
        .clk     (clk),
        .we      (coef_we),
        .waddr   (COEF_AW'(coef_index)),
        .wdata   (coef_value),
        .re      (cmd.tap_step),
        .raddr   (k_reg),
        .rd_data (coef_rd)
    );

    // multiply-accumulate
    logic                     v1_reg, v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_step;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= $signed(coef_rd) * $signed({1'b0, line_rd});
        end
        if (cmd.tap_start)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // clamp: nonpositive -> 0, else truncate fraction and saturate
    logic signed [ACC_W-1:0] acc_q;
    logic [7:0]              sat_pix;

    assign acc_q = acc_reg >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (acc_reg <= 0)
            sat_pix = 8'd0;
        else if (acc_q > ACC_W'(PIX_MAX))
            sat_pix = 8'(PIX_MAX);
        else
            sat_pix = acc_q[7:0];
    end

    // result register
    logic       res_valid_reg;
    logic [7:0] res_pix_reg;
    logic [9:0] res_col_reg, res_row_reg;
    logic       res_last_reg;
    logic       col_last;

    assign col_last = (cur_col_reg == hi_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_pix_reg  <= sat_pix;
            res_col_reg  <= cur_col_reg[9:0];
            res_row_reg  <= orow_reg[9:0];
            res_last_reg <= col_last;
        end
    end

    assign result_valid  = res_valid_reg;
    assign result_pixel  = res_pix_reg;
    assign result_column = res_col_reg;
    assign result_row    = res_row_reg;
    assign last_of_run   = res_last_reg;

    assign stat.emits     = emits_reg;
    assign stat.tap_last  = tap_last;
    assign stat.col_last  = col_last;
    assign stat.pipe_busy = v1_reg || v2_reg;
    assign stat.out_free  = !res_valid_reg || result_ready;

endmodule

// File: rtl/core/image_convolution_replicate_pad.sv
// Streaming square 2D convolution (radius 1..3) with replicated borders over 8-bit pixels.
// Items are taken one at a time. Each result is computed by a single multiply-accumulate
// unit that sweeps the (2r+1)^2 kernel taps, one line-store read per cycle, followed by
// pipeline drain and hand-off; an item yields n results, n being 0..4 (up to r+1 at a row
// end). The single read port of the line store sets the pace of the tap sweep. The
// last result of an item sits in an output register while the next item is taken. Line
// store and coefficient table come up unwritten: load every coefficient before streaming
// a plane, and start each plane with frame_start. No clearing pass.
module image_convolution_replicate_pad
    import icrp_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL     = DEF_MAX_KERNEL,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         func,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    input  logic [7:0]         pixel,
    input  logic               frame_start,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [7:0]         result_pixel,
    output logic [9:0]         result_column,
    output logic [9:0]         result_row,
    output logic               last_of_run
);

    icrp_cmd_t  cmd;
    icrp_stat_t stat;

    assign cfg_ready = 1'b1;

    icrp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    icrp_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_KERNEL     (MAX_KERNEL),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .pixel         (pixel),
        .frame_start   (frame_start),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_pixel  (result_pixel),
        .result_column (result_column),
        .result_row    (result_row),
        .last_of_run   (last_of_run)
    );

endmodule

// File: tb/sv/icrp_checker.sv
// Channel monitor, convolution predictor and result comparison for the convolution block.
module icrp_checker
    import icrp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic [1:0]         func,
    input  logic [5:0]         coef_index,
    input  logic signed [15:0] coef_value,
    input  logic [7:0]         pixel,
    input  logic               frame_start,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [7:0]         result_pixel,
    input  logic [9:0]         result_column,
    input  logic [9:0]         result_row,
    input  logic               last_of_run,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KSIDE = DEF_MAX_KERNEL;
    localparam int LWIDTH = DEF_MAX_WIDTH;

    typedef struct {
        logic [7:0] pix;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } conv_out_t;

    conv_out_t        pending_px[$];
    logic [10:0]      width_reg;
    logic [10:0]      height_reg;
    logic [1:0]       radius_reg;
    logic signed [15:0] kernel_tab[KSIDE*KSIDE];
    logic [7:0]       line_mem[KSIDE*LWIDTH];
    int unsigned      col_pos;
    int unsigned      row_pos;

    function automatic int unsigned clampi(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] conv_at(int orow, int ocol, int w, int h, int r);
        longint acc;
        int     side;
        int     rr;
        int     cc;
        acc  = 0;
        side = 2 * r + 1;
        for (int i = 0; i < side; i++)
        begin
            rr = clampi(orow + i - r, 0, h - 1);
            for (int j = 0; j < side; j++)
            begin
                cc = clampi(ocol + j - r, 0, w - 1);
                acc += longint'(kernel_tab[i*side+j]) *
                       longint'(line_mem[(rr % KSIDE) * LWIDTH + cc]);
            end
        end
        if (acc <= 0)
            return 8'd0;
        acc = acc >>> DEF_COEF_FRAC_BITS;
        return (acc > PIX_MAX) ? 8'(PIX_MAX) : 8'(acc);
    endfunction

    task automatic predict_item();
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned rw;
        int unsigned cl;
        int unsigned lo;
        int unsigned hi;
        int          n;
        conv_out_t   res;
        if (func == FUNC_COEF)
        begin
            if (coef_index < KSIDE * KSIDE)
                kernel_tab[coef_index] = coef_value;
            return;
        end
        if (func != FUNC_PIXEL && func != FUNC_DRAIN)
            return;
        if (frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        w = (width_reg == 0) ? 1 : (width_reg > LWIDTH) ? LWIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        r = (radius_reg == 0) ? 1 : radius_reg;
        rw = row_pos;
        cl = col_pos;
        if (rw >= h + r)
            return;
        // drain items inside the image store their pixel too
        if (rw < h && cl < LWIDTH)
            line_mem[(rw % KSIDE) * LWIDTH + cl] = pixel;
        if (rw >= r)
        begin
            n = 0;
            if (cl >= w - 1)
            begin
                lo = (cl >= r) ? cl - r : 0;
                hi = w - 1;
            end
            else
            begin
                lo = (cl >= r) ? cl - r : 1;
                hi = (cl >= r) ? cl - r : 0;
            end
            for (int unsigned c = lo; c <= hi && n < MAX_RESULTS; c++)
            begin
                res.pix  = conv_at(rw - r, c, w, h, r);
                res.col  = 10'(c);
                res.row  = 10'(rw - r);
                res.last = 1'b0;
                pending_px.push_back(res);
                n++;
            end
            if (n > 0)
                pending_px[pending_px.size()-1].last = 1'b1;
        end
        if (cl >= w - 1)
        begin
            col_pos = 0;
            row_pos = rw + 1;
        end
        else
            col_pos = cl + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        conv_out_t want;
        if (!rst_n)
        begin
            width_reg  = 11'd1024;
            height_reg = 11'd1024;
            radius_reg = 2'd1;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            pending_px.delete();
        end
        else
        begin
            // compare first: an output in this cycle belongs to an earlier transaction
            if (result_valid && result_ready)
            begin
                if (pending_px.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result pix=%0d col=%0d row=%0d last=%0b",
                             $time, result_pixel, result_column, result_row, last_of_run);
                end
                else
                begin
                    want = pending_px.pop_front();
                    if (want.pix !== result_pixel || want.col !== result_column ||
                        want.row !== result_row || want.last !== last_of_run)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected pix=%0d col=%0d row=%0d last=%0b",
                                 $time, want.pix, want.col, want.row, want.last);
                        $display("%0t:          actual   pix=%0d col=%0d row=%0d last=%0b",
                                 $time, result_pixel, result_column, result_row, last_of_run);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    CFG_RADIUS: radius_reg = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
                predict_item();
        end
        outstanding = pending_px.size();
    end

endmodule

// File: tb/sv/tb_image_convolution_replicate_pad.sv
// Testbench top: stimulus, handshake pacing and verdict for the convolution block.
module tb_image_convolution_replicate_pad;
    import icrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 300;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               item_valid;
    logic               item_ready;
    logic [1:0]         func;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]         pixel;
    logic               frame_start;
    logic               result_valid;
    logic               result_ready;
    logic [7:0]         result_pixel;
    logic [9:0]         result_column;
    logic [9:0]         result_row;
    logic               last_of_run;
    int                 mismatches;
    int                 outstanding;
    int                 cycles;
    bit                 no_gaps;
    bit                 long_hold;

    image_convolution_replicate_pad dut (.*);

    icrp_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("image_convolution_replicate_pad regression: fail");
                $finish;
            end
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int pause;
        bit hold_done;
        hold_done    = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                pause = 400;
            end
            else
                pause = no_gaps ? 0 : $urandom_range(0, 3);
            if (pause > 0)
            begin
                result_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(logic [1:0] f, logic [5:0] ci, logic [15:0] cv,
                        logic [7:0] px, logic fs);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func        <= f;
        coef_index  <= ci;
        coef_value  <= cv;
        pixel       <= px;
        frame_start <= fs;
        item_valid  <= 1'b1;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic quiesce();
        item_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic load_kernel(bit wide);
        for (int k = 0; k < 49; k++)
            send(FUNC_COEF, 6'(k), wide ? 16'($urandom) : 16'($urandom_range(0, 260) - 60),
                 8'($urandom), 1'($urandom));
    endtask

    // one plane; when noisy, swaps pixel/drain roles and slips in no-op and coefficient items now and then
    task automatic run_plane(logic [10:0] w_raw, logic [10:0] h_raw, logic [1:0] r_raw,
                             bit noisy, bit stall);
        int w;
        int h;
        int r;
        logic [1:0] f;
        quiesce();
        write_reg(CFG_WIDTH, w_raw);
        write_reg(CFG_HEIGHT, h_raw);
        write_reg(CFG_RADIUS, r_raw);
        w = (w_raw == 0) ? 1 : (w_raw > 1024) ? 1024 : w_raw;
        h = (h_raw == 0) ? 1 : (h_raw > 1024) ? 1024 : h_raw;
        r = (r_raw == 0) ? 1 : r_raw;
        for (int y = 0; y < h + r; y++)
            for (int x = 0; x < w; x++)
            begin
                if (stall && y == 0 && x == 0)
                    long_hold = 1'b1;
                f = (y < h) ? FUNC_PIXEL : FUNC_DRAIN;
                if (noisy && $urandom_range(0, 9) == 0)
                    f = (f == FUNC_PIXEL) ? FUNC_DRAIN : FUNC_PIXEL;
                if (noisy && $urandom_range(0, 19) == 0)
                    send(FUNC_NONE, 6'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
                if (noisy && $urandom_range(0, 29) == 0)
                    send(FUNC_COEF, 6'($urandom_range(0, 48)), 16'($urandom_range(0, 200)),
                         8'($urandom), 1'b0);
                send(f, 6'($urandom), 16'($urandom), 8'($urandom), (y == 0 && x == 0));
            end
        // the plane is finished: these are ignored until a new frame starts
        if (noisy)
            repeat ($urandom_range(1, 3))
                send($urandom_range(0, 1) ? FUNC_PIXEL : FUNC_DRAIN, 6'($urandom),
                     16'($urandom), 8'($urandom), 1'b0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WIDTH;
        cfg_data    = '0;
        item_valid  = 1'b0;
        func        = FUNC_NONE;
        coef_index  = '0;
        coef_value  = '0;
        pixel       = '0;
        frame_start = 1'b0;
        no_gaps     = 1'b0;
        long_hold   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: full kernel, ignored codes and out-of-range indexes
        load_kernel(1'b0);
        send(FUNC_COEF, 6'd49, 16'h7FFF, 8'hFF, 1'b1);
        send(FUNC_COEF, 6'd63, 16'h8000, 8'h00, 1'b0);
        send(FUNC_NONE, 6'd63, 16'hFFFF, 8'hFF, 1'b1);
        run_plane(11'd1, 11'd1, 2'd1, 1'b0, 1'b0);
        run_plane(11'd0, 11'd0, 2'd0, 1'b0, 1'b0);
        send(FUNC_COEF, 6'd4, 16'h7FFF, 8'h00, 1'b0);
        send(FUNC_COEF, 6'd0, 16'h8000, 8'h00, 1'b0);
        run_plane(11'd4, 11'd3, 2'd1, 1'b0, 1'b0);
        send(FUNC_COEF, 6'd24, 16'h7FFF, 8'h00, 1'b0);
        send(FUNC_COEF, 6'd48, 16'h8000, 8'h00, 1'b0);
        run_plane(11'd3, 11'd2, 2'd3, 1'b0, 1'b0);

        // random planes, the first one under a long result hold-off
        for (int p = 0; p < 2; p++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            run_plane((p == 0) ? 11'd5 : 11'($urandom_range(1, 4)),
                      (p == 0) ? 11'd2 : 11'($urandom_range(1, 3)),
                      2'($urandom_range(1, 3)), $urandom_range(0, 2) != 0, p == 0);
        end
        no_gaps = 1'b0;

        quiesce();
        if (mismatches == 0)
            $display("image_convolution_replicate_pad regression: pass");
        else
            $display("image_convolution_replicate_pad regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/icrp_pkg.sv
rtl/core/icrp_ram.sv
rtl/core/icrp_ctrl.sv
rtl/core/icrp_dp.sv
rtl/core/image_convolution_replicate_pad.sv
tb/sv/icrp_checker.sv
tb/sv/tb_image_convolution_replicate_pad.sv
